FILE: design/assert_macros.svh
// Assertion macros shared by the encoder and button event decoder modules.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define EABD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Antecedent in one cycle implies the consequent in the next.
`define EABD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define EABD_ASSERT(lbl, clk, rst_n, prop)
`define EABD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: design/eabd_pkg.sv
// Package for the encoder and button event decoder: sizes, codes, queue item type
// and the quadrature state table. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package eabd_pkg;

  // Sizes of the block.
  localparam int unsigned PENDING_BITS = 16;
  localparam int unsigned BUTTON_COUNT = 3;
  localparam int unsigned PIN_COUNT    = 3;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam int unsigned TIME_BITS      = 32;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned IN_DATA_BITS   = 40;
  localparam int unsigned OUT_DATA_BITS  = 8;
  localparam int unsigned EVENT_BITS     = 3;

  // Bit positions in the input tdata.
  localparam int unsigned IN_ENC_A_BIT  = 0;
  localparam int unsigned IN_ENC_B_BIT  = 1;
  localparam int unsigned IN_SWITCH_BIT = 2;
  localparam int unsigned IN_BUTTON_LSB = 3;
  localparam int unsigned IN_NOW_LSB    = 6;

  // Configuration register indexes and reset values.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE   = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LONG_PRESS = CFG_INDEX_BITS'(1);
  localparam logic [CFG_DATA_BITS-1:0]  DEBOUNCE_RESET   = CFG_DATA_BITS'(30);
  localparam logic [CFG_DATA_BITS-1:0]  LONG_PRESS_RESET = CFG_DATA_BITS'(600);

  // Saturation limits of the signed pending detent count.
  localparam logic signed [PENDING_BITS-1:0] PEND_MAX = {1'b0, {(PENDING_BITS-1){1'b1}}};
  localparam logic signed [PENDING_BITS-1:0] PEND_MIN = {1'b1, {(PENDING_BITS-1){1'b0}}};

  // Event codes; buttons take consecutive codes from EVT_BUTTON1 upwards.
  typedef enum logic [EVENT_BITS-1:0] {
    EVT_NONE    = 3'd0,
    EVT_CW      = 3'd1,
    EVT_CCW     = 3'd2,
    EVT_LONG    = 3'd3,
    EVT_SHORT   = 3'd4,
    EVT_BUTTON1 = 3'd5
  } event_e;

  // Full-step quadrature table: low three bits hold the next state, the upper
  // bits flag a completed clockwise or counter-clockwise detent.
  localparam logic [7:0] QSTATE_MASK = 8'h07;
  localparam logic [7:0] DETENT_CW   = 8'h10;
  localparam logic [7:0] DETENT_CCW  = 8'h20;
  localparam int unsigned QUAD_STATES = 7;

  localparam logic [7:0] QUAD_TABLE [QUAD_STATES][4] = '{
    '{8'h00, 8'h02, 8'h04, 8'h00},
    '{8'h03, 8'h00, 8'h01, 8'h00 | DETENT_CW},
    '{8'h03, 8'h02, 8'h00, 8'h00},
    '{8'h03, 8'h02, 8'h01, 8'h00},
    '{8'h06, 8'h00, 8'h04, 8'h00},
    '{8'h06, 8'h05, 8'h00, 8'h00 | DETENT_CCW},
    '{8'h06, 8'h05, 8'h04, 8'h00}
  };

  // An item as it passes from the front part to the back part.
  typedef struct packed {
    logic [EVENT_BITS-1:0] event_code;  // rotation event, or none
    logic                  switch_pin;
    logic [PIN_COUNT-1:0]  button_pins;
    logic [TIME_BITS-1:0]  now_ms;
  } entry_t;

endpackage

FILE: design/eabd_front.sv
// Front part: accepts samples, runs the quadrature machine and the pending
// detent count, and tags each item with its rotation event. Depends on eabd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eabd_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [eabd_pkg::IN_DATA_BITS-1:0]   in_data_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output eabd_pkg::entry_t                    push_entry_o
);
  import eabd_pkg::*;

  logic [2:0]                     quad_q, quad_d;
  logic signed [PENDING_BITS-1:0] pending_q, pending_d, pending_det;
  logic [2:0]                     quad_row;
  logic [1:0]                     quad_pins;
  logic [7:0]                     quad_entry;
  logic                           in_fire;
  logic [EVENT_BITS-1:0]          rot_event;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign in_fire      = in_valid_i & push_ready_i;

  // Quadrature table lookup; the unused state code falls back to the start row.
  assign quad_row   = (quad_q == 3'(QUAD_STATES)) ? 3'd0 : quad_q;
  assign quad_pins  = {in_data_i[IN_ENC_A_BIT], in_data_i[IN_ENC_B_BIT]};
  assign quad_entry = QUAD_TABLE[quad_row][quad_pins];
  assign quad_d     = 3'(quad_entry & QSTATE_MASK);

  // Add a completed detent with saturation, then move one step toward zero.
  always_comb begin
    pending_det = pending_q;
    if ((quad_entry & DETENT_CW) != 8'h00) begin
      if (pending_q != PEND_MAX) pending_det = pending_q + PENDING_BITS'(1);
    end else if ((quad_entry & DETENT_CCW) != 8'h00) begin
      if (pending_q != PEND_MIN) pending_det = pending_q - PENDING_BITS'(1);
    end
    pending_d = pending_det;
    rot_event = EVT_NONE;
    if (pending_det[PENDING_BITS-1]) begin
      pending_d = pending_det + PENDING_BITS'(1);
      rot_event = EVT_CCW;
    end else if (pending_det != '0) begin
      pending_d = pending_det - PENDING_BITS'(1);
      rot_event = EVT_CW;
    end
  end

  always_comb begin
    push_entry_o.event_code  = rot_event;
    push_entry_o.switch_pin  = in_data_i[IN_SWITCH_BIT];
    push_entry_o.button_pins = in_data_i[IN_BUTTON_LSB +: PIN_COUNT];
    push_entry_o.now_ms      = in_data_i[IN_NOW_LSB +: TIME_BITS];
  end

  // Encoder state advances only on accepted items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quad_q    <= 3'd0;
      pending_q <= '0;
    end else if (in_fire) begin
      quad_q    <= quad_d;
      pending_q <= pending_d;
    end
  end

  // An item without a rotation event leaves no detents pending.
  `EABD_ASSERT_NEXT(a_idle_drains, clk_i, rst_ni, in_fire && (rot_event == EVT_NONE), pending_q == '0)

endmodule

FILE: design/eabd_queue.sv
// Short queue between the front and back parts of the event decoder.
// Holds QUEUE_DEPTH items in flip-flops; depends on eabd_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eabd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  eabd_pkg::entry_t push_entry_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output eabd_pkg::entry_t pop_entry_o
);
  import eabd_pkg::*;

  localparam int unsigned PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  entry_t               mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]   count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q != CntBits'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Pointers wrap naturally as the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      if (push && !pop)      count_q <= count_q + CntBits'(1);
      else if (pop && !push) count_q <= count_q - CntBits'(1);
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_entry_i;
  end

  `EABD_ASSERT_NEXT(a_fill_count, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + CntBits'(1))

endmodule

FILE: design/eabd_back.sv
// Back part: switch long and short press detection, debounced button scan and
// the output register. Depends on eabd_pkg and the configuration values.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eabd_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [eabd_pkg::CFG_DATA_BITS-1:0] debounce_ms_i,
  input  logic [eabd_pkg::CFG_DATA_BITS-1:0] long_press_ms_i,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  eabd_pkg::entry_t                   pop_entry_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [eabd_pkg::EVENT_BITS-1:0]    out_event_o
);
  import eabd_pkg::*;

  logic                  switch_down_q, switch_down_d;
  logic [TIME_BITS-1:0]  switch_time_q, switch_time_d;
  logic                  long_fired_q, long_fired_d;
  logic                  button_down_q [BUTTON_COUNT];
  logic                  button_down_d [BUTTON_COUNT];
  logic [TIME_BITS-1:0]  button_time_q [BUTTON_COUNT];
  logic [TIME_BITS-1:0]  button_time_d [BUTTON_COUNT];
  logic                  out_valid_q;
  logic [EVENT_BITS-1:0] out_event_q, event_d;
  logic                  pop, sw_held, found, pressed, settled;
  logic [TIME_BITS-1:0]  sw_elapsed, now, debounce_ext, long_ext;

  assign pop_ready_o  = ~out_valid_q | out_ready_i;
  assign pop          = pop_valid_i & pop_ready_o;
  assign now          = pop_entry_i.now_ms;
  assign sw_held      = ~pop_entry_i.switch_pin;
  assign debounce_ext = TIME_BITS'(debounce_ms_i);
  assign long_ext     = TIME_BITS'(long_press_ms_i);

  // Event choice: rotation first, then the switch, then buttons in order.
  always_comb begin
    switch_down_d = switch_down_q;
    switch_time_d = switch_time_q;
    long_fired_d  = long_fired_q;
    button_down_d = button_down_q;
    button_time_d = button_time_q;
    event_d       = EVT_NONE;
    found         = 1'b0;
    sw_elapsed    = '0;
    pressed       = 1'b0;
    settled       = 1'b0;
    if (pop_entry_i.event_code != EVT_NONE) begin
      event_d = pop_entry_i.event_code;
    end else begin
      if (sw_held && !switch_down_q) begin
        switch_down_d = 1'b1;
        switch_time_d = now;
        long_fired_d  = 1'b0;
      end
      sw_elapsed = now - switch_time_d;
      if (sw_held && !long_fired_d && (sw_elapsed >= long_ext)) begin
        long_fired_d = 1'b1;
        event_d      = EVT_LONG;
        found        = 1'b1;
      end else if (!sw_held && switch_down_q) begin
        switch_down_d = 1'b0;
        if (!long_fired_q && (sw_elapsed > debounce_ext)) begin
          event_d = EVT_SHORT;
          found   = 1'b1;
        end
      end
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        if (i < PIN_COUNT) pressed = ~pop_entry_i.button_pins[2'(i)];
        else pressed = 1'b0;
        settled = (now - button_time_q[i]) > debounce_ext;
        if (!found && settled) begin
          if (pressed && !button_down_q[i]) begin
            button_down_d[i] = 1'b1;
            button_time_d[i] = now;
            event_d          = EVENT_BITS'(EVT_BUTTON1 + i);
            found            = 1'b1;
          end else if (!pressed && button_down_q[i]) begin
            button_down_d[i] = 1'b0;
            button_time_d[i] = now;
          end
        end
      end
    end
  end

  // Press state advances only on items taken from the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_down_q <= 1'b0;
      switch_time_q <= '0;
      long_fired_q  <= 1'b0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        button_down_q[i] <= 1'b0;
        button_time_q[i] <= '0;
      end
    end else if (pop) begin
      switch_down_q <= switch_down_d;
      switch_time_q <= switch_time_d;
      long_fired_q  <= long_fired_d;
      button_down_q <= button_down_d;
      button_time_q <= button_time_d;
    end
  end

  // Output register: refilled whenever it is empty or being drained.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      out_valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) out_event_q <= event_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_event_o = out_event_q;

  `EABD_ASSERT_NEXT(a_long_held, clk_i, rst_ni, pop && (event_d == EVT_LONG), switch_down_q && long_fired_q)
  `EABD_ASSERT(a_short_release, clk_i, rst_ni, (pop && (event_d == EVT_SHORT)) |-> (switch_down_q && !long_fired_q))

endmodule

FILE: design/encoder_and_button_event_decoder_unit.sv
// Top level of the encoder and button event decoder: configuration registers,
// front part, item queue and back part. Depends on eabd_pkg and its submodules.
`timescale 1ns / 1ps
// Usage
// Each input item on the s_axis channel is one sample of the encoder A/B levels,
// the encoder switch, three buttons (low means pressed) and the millisecond time.
// Every item gives exactly one result item on the m_axis channel: a 3-bit event
// code (none, rotate cw, rotate ccw, long push, short push, button 1 to 3).
// The cfg channel writes debounce_ms (index 0) and long_press_ms (index 1); other
// indexes are ignored. It is always ready and should be written while idle.
// Throughput is one item per clock cycle while the receiver keeps up. An accepted
// item is first written into the queue, and the back part then loads its result
// into its output register, where it is held until it is taken.
// When the receiver stalls, the output register and the two-entry queue fill and
// s_axis_tready_o drops; no item is lost or repeated.
// After reset the quadrature machine is in its start state, all press state and
// time stamps are zero, and the configuration holds 30 ms and 600 ms. No
// clearing pass is needed: the block accepts items in the first cycle.
module encoder_and_button_event_decoder_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Fields from bit 0: enc_a, enc_b, switch_pin, button1_pin, button2_pin,
  // button3_pin, now_ms[31:0], zero fill.
  input  logic [eabd_pkg::IN_DATA_BITS-1:0]    s_axis_tdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // Fields from bit 0: event_code[2:0], zero fill.
  output logic [eabd_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [eabd_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [eabd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import eabd_pkg::*;

  logic [CFG_DATA_BITS-1:0] debounce_q, long_press_q;
  logic                     front_valid, front_ready, back_valid, back_ready;
  entry_t                   front_entry, back_entry;
  logic [EVENT_BITS-1:0]    out_event;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RESET;
      long_press_q <= LONG_PRESS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        CFG_LONG_PRESS: long_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  eabd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_data_i    (s_axis_tdata_i),
    .push_valid_o (front_valid),
    .push_ready_i (front_ready),
    .push_entry_o (front_entry)
  );

  eabd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_entry_i (front_entry),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_entry_o  (back_entry)
  );

  eabd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .debounce_ms_i   (debounce_q),
    .long_press_ms_i (long_press_q),
    .pop_valid_i     (back_valid),
    .pop_ready_o     (back_ready),
    .pop_entry_i     (back_entry),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_event_o     (out_event)
  );

  assign m_axis_tdata_o = OUT_DATA_BITS'(out_event);

endmodule
